@@ design/mdesc_pkg.sv @@
`default_nettype none

package mdesc_pkg;

    // Marker storage is fixed by the register map: four 64-bit words of bytes.
    localparam int MARKER_BYTES   = 32;
    localparam int MARKER_MAX_DEF = 32;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int LENGTH_W       = 6;
    localparam int LIMIT_W        = 8;
    localparam int COUNT_W        = 9;

    // Escape filter byte codes.
    localparam logic [7:0] BYTE_ESC       = 8'h1B;
    localparam logic [7:0] BYTE_FINAL_LO  = 8'h40;
    localparam logic [7:0] BYTE_FINAL_HI  = 8'h7E;
    localparam logic [7:0] BYTE_CSI_OPEN  = 8'h5B;
    localparam logic [7:0] BYTE_BACKSPACE = 8'h08;
    localparam logic [7:0] BYTE_NUL       = 8'h00;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 9'd511;
    localparam logic [COUNT_W:0]   OVF_MARGIN = 10'd3;

    // Reset values of the configuration registers.
    localparam logic [LENGTH_W-1:0] LENGTH_RESET = 6'd26;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 8'd199;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MARKER_LENGTH = 3'd0,
        REG_MARKER_WORD_0 = 3'd1,
        REG_MARKER_WORD_1 = 3'd2,
        REG_MARKER_WORD_2 = 3'd3,
        REG_MARKER_WORD_3 = 3'd4,
        REG_CAPTURE_LIMIT = 3'd5
    } reg_index_t;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_CAPT = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pending;
        logic slot_free;
        logic is_last;
    } status_t;

    // Pick one marker byte out of the four packed words.
    function automatic logic [7:0] marker_byte(input logic [3:0][63:0] words,
                                               input logic [4:0] idx);
        return words[idx[4:3]][{idx[2:0], 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

@@ design/mdesc_ctrl.sv @@
`default_nettype none

module mdesc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire mdesc_pkg::status_t status,
    output mdesc_pkg::cmd_t        cmd
);
    import mdesc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // An item is taken only in idle; the results then go out one per free slot.
    always_comb
    begin
        in_stall   = 1'b1;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!status.pending)
                begin
                    state_next = S_IDLE;
                end
                else if (status.slot_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.is_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

@@ design/mdesc_datapath.sv @@
`default_nettype none

module mdesc_datapath #(
    parameter int MARKER_MAX = mdesc_pkg::MARKER_MAX_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [mdesc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [mdesc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic [7:0]                          in_byte,
    input  wire mdesc_pkg::cmd_t                     cmd,
    output mdesc_pkg::status_t                       status,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output mdesc_pkg::kind_t                         kind,
    output logic [7:0]                               out_byte,
    output logic                                     overflow,
    output logic                                     last
);
    import mdesc_pkg::*;

    localparam int MPW = $clog2(MARKER_MAX + 1);

    // Configuration registers.
    logic [LENGTH_W-1:0] marker_length_reg;
    logic [3:0][63:0]    marker_reg;
    logic [LIMIT_W-1:0]  capture_limit_reg;

    // Scan state.
    logic [MPW-1:0]     match_position_reg;
    logic [MPW-1:0]     match_position_next;
    logic               capturing_reg;
    logic               capturing_next;
    logic               in_escape_reg;
    logic               in_escape_next;
    logic [COUNT_W-1:0] capture_count_reg;
    logic [COUNT_W-1:0] capture_count_next;

    // Plan of the results for the current item.
    logic [MPW-1:0] flush_count_reg;
    logic [MPW-1:0] flush_count_next;
    logic [MPW-1:0] flush_index_reg;
    logic [MPW-1:0] flush_index_next;
    logic           echo_reg;
    logic           echo_next;
    logic           capt_reg;
    logic           capt_next;
    logic           end_reg;
    logic           end_next;
    logic           ovf_reg;
    logic           ovf_next;
    logic [7:0]     byte_reg;

    // Output register.
    logic           out_valid_reg;
    logic           out_valid_next;
    kind_t          kind_reg;
    kind_t          kind_next;
    logic [7:0]     out_byte_reg;
    logic [7:0]     out_byte_next;
    logic           overflow_reg;
    logic           overflow_next;
    logic           last_reg;
    logic           last_next;

    logic [LENGTH_W-1:0] length_clamped;
    logic [MPW-1:0]      active_length;
    logic                is_match;
    logic                capture_on;
    logic [COUNT_W-1:0]  count_step;
    logic                flush_left;

    // Clamp the configured length into one to the largest marker.
    always_comb
    begin
        if (marker_length_reg == '0)
        begin
            length_clamped = LENGTH_W'(1);
        end
        else if (marker_length_reg > LENGTH_W'(MARKER_MAX))
        begin
            length_clamped = LENGTH_W'(MARKER_MAX);
        end
        else
        begin
            length_clamped = marker_length_reg;
        end
        active_length = MPW'(length_clamped);
    end

    assign is_match = (match_position_reg < active_length) &&
                      (in_byte == marker_byte(marker_reg, 5'(match_position_reg)));

    // Work out the new scan state and the results an incoming item causes.
    always_comb
    begin
        match_position_next = match_position_reg;
        capturing_next      = capturing_reg;
        in_escape_next      = in_escape_reg;
        capture_count_next  = capture_count_reg;
        flush_count_next    = '0;
        echo_next           = 1'b0;
        capt_next           = 1'b0;
        end_next            = 1'b0;
        ovf_next            = 1'b0;
        count_step          = capture_count_reg;

        if (is_match)
        begin
            match_position_next = match_position_reg + MPW'(1);
        end
        else
        begin
            if (match_position_reg >= active_length)
            begin
                capturing_next = 1'b1;
            end
            else
            begin
                flush_count_next = match_position_reg;
            end
            match_position_next = '0;
            echo_next           = 1'b1;
        end

        capture_on = capturing_next;
        if (capture_on)
        begin
            priority if (in_byte == BYTE_ESC)
            begin
                in_escape_next = 1'b1;
            end
            else if (in_escape_reg && in_byte >= BYTE_FINAL_LO &&
                     in_byte <= BYTE_FINAL_HI && in_byte != BYTE_CSI_OPEN)
            begin
                in_escape_next = 1'b0;
            end
            else if (!in_escape_reg && in_byte != BYTE_BACKSPACE)
            begin
                capt_next = (capture_count_reg < COUNT_W'(capture_limit_reg)) &&
                            (in_byte != BYTE_NUL);
                if (capture_count_reg < COUNT_MAX)
                begin
                    count_step = capture_count_reg + COUNT_W'(1);
                end
            end
            else
            begin
                count_step = capture_count_reg;
            end
            capture_count_next = count_step;

            // A zero byte closes the capture.
            if (in_byte == BYTE_NUL)
            begin
                end_next           = 1'b1;
                ovf_next           = {1'b0, count_step} >
                                     ((COUNT_W+1)'(capture_limit_reg) + OVF_MARGIN);
                capture_count_next = '0;
                capturing_next     = 1'b0;
            end
        end
    end

    assign flush_left = (flush_index_reg < flush_count_reg);

    // Status toward the controller.
    always_comb
    begin
        status.pending   = flush_left || echo_reg || capt_reg || end_reg;
        status.slot_free = !out_valid_reg || !out_stall;
        priority if (flush_left)
        begin
            status.is_last = (flush_index_reg + MPW'(1) == flush_count_reg) &&
                             !echo_reg && !capt_reg && !end_reg;
        end
        else if (echo_reg)
        begin
            status.is_last = !capt_reg && !end_reg;
        end
        else if (capt_reg)
        begin
            status.is_last = !end_reg;
        end
        else
        begin
            status.is_last = 1'b1;
        end
    end

    // Pick the next result in order: held marker bytes, echo, capture, end.
    always_comb
    begin
        kind_next        = kind_reg;
        out_byte_next    = out_byte_reg;
        overflow_next    = overflow_reg;
        last_next        = last_reg;
        flush_index_next = flush_index_reg;
        out_valid_next   = out_valid_reg && out_stall;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            last_next      = status.is_last;
            overflow_next  = 1'b0;
            priority if (flush_left)
            begin
                kind_next        = KIND_ECHO;
                out_byte_next    = marker_byte(marker_reg, 5'(flush_index_reg));
                flush_index_next = flush_index_reg + MPW'(1);
            end
            else if (echo_reg)
            begin
                kind_next     = KIND_ECHO;
                out_byte_next = byte_reg;
            end
            else if (capt_reg)
            begin
                kind_next     = KIND_CAPT;
                out_byte_next = byte_reg;
            end
            else
            begin
                kind_next     = KIND_END;
                out_byte_next = BYTE_NUL;
                overflow_next = ovf_reg;
            end
        end
    end

    // Control and scan state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_length_reg  <= LENGTH_RESET;
            marker_reg         <= '0;
            capture_limit_reg  <= LIMIT_RESET;
            match_position_reg <= '0;
            capturing_reg      <= 1'b0;
            in_escape_reg      <= 1'b0;
            capture_count_reg  <= '0;
            flush_count_reg    <= '0;
            flush_index_reg    <= '0;
            echo_reg           <= 1'b0;
            capt_reg           <= 1'b0;
            end_reg            <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_MARKER_LENGTH: marker_length_reg <= cfg_data[LENGTH_W-1:0];
                    REG_MARKER_WORD_0: marker_reg[0]     <= cfg_data;
                    REG_MARKER_WORD_1: marker_reg[1]     <= cfg_data;
                    REG_MARKER_WORD_2: marker_reg[2]     <= cfg_data;
                    REG_MARKER_WORD_3: marker_reg[3]     <= cfg_data;
                    REG_CAPTURE_LIMIT: capture_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            out_valid_reg <= out_valid_next;

            if (cmd.load)
            begin
                match_position_reg <= match_position_next;
                capturing_reg      <= capturing_next;
                in_escape_reg      <= in_escape_next;
                capture_count_reg  <= capture_count_next;
                flush_count_reg    <= flush_count_next;
                flush_index_reg    <= '0;
                echo_reg           <= echo_next;
                capt_reg           <= capt_next;
                end_reg            <= end_next;
            end
            else if (cmd.emit)
            begin
                flush_index_reg <= flush_index_next;
                if (!flush_left)
                begin
                    priority if (echo_reg)
                    begin
                        echo_reg <= 1'b0;
                    end
                    else if (capt_reg)
                    begin
                        capt_reg <= 1'b0;
                    end
                    else
                    begin
                        end_reg <= 1'b0;
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= in_byte;
            ovf_reg  <= ovf_next;
        end
        kind_reg     <= kind_next;
        out_byte_reg <= out_byte_next;
        overflow_reg <= overflow_next;
        last_reg     <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign out_byte  = out_byte_reg;
    assign overflow  = overflow_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

@@ design/marker_detect_escape_strip_capture.sv @@
// Flow: an item is taken only while idle, and no new item is taken until every result
// that it causes is out; the results leave one at a time through the single output
// register, one per free slot, so a stalled output holds the flow. An item usually
// causes a single result, and more when a held marker is flushed.
// Reset: asynchronous, active low; clears the scan state and output valid and loads
// the register reset values (length 26, marker zero, limit 199).
`default_nettype none

module marker_detect_escape_strip_capture #(
    parameter int MARKER_MAX = mdesc_pkg::MARKER_MAX_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [mdesc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [mdesc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [7:0]                        in_byte,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output mdesc_pkg::kind_t                       kind,
    output logic [7:0]                             out_byte,
    output logic                                   overflow,
    output logic                                   last
);
    import mdesc_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer that takes items and paces the results.
    mdesc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Registers, matcher, escape filter and output register.
    mdesc_datapath #(
        .MARKER_MAX (MARKER_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (in_byte),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .overflow  (overflow),
        .last      (last)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
module tb_top;
    import mdesc_pkg::*;

    // One result as the block should present it.
    typedef struct {
        kind_t      kind;
        logic [7:0] data;
        logic       ovf;
        logic       last;
    } echo_result_t;

    // Tracks the marker scanner and capture filter, and holds the results still owed.
    class echo_capture_tracker;
        logic [LENGTH_W-1:0] length_reg;
        logic [3:0][63:0]    marker_words;
        logic [LIMIT_W-1:0]  limit_reg;
        logic [5:0]          match_pos;
        logic                capturing;
        logic                in_escape;
        logic [COUNT_W-1:0]  capture_count;
        echo_result_t        expected_results[$];
        int                  mismatch_count;

        function new();
            length_reg     = LENGTH_RESET;
            marker_words   = '0;
            limit_reg      = LIMIT_RESET;
            match_pos      = '0;
            capturing      = 1'b0;
            in_escape      = 1'b0;
            capture_count  = '0;
            mismatch_count = 0;
        endfunction

        function void write_reg(reg_index_t idx, logic [63:0] value);
            case (idx)
                REG_MARKER_LENGTH: length_reg = value[LENGTH_W-1:0];
                REG_MARKER_WORD_0: marker_words[0] = value;
                REG_MARKER_WORD_1: marker_words[1] = value;
                REG_MARKER_WORD_2: marker_words[2] = value;
                REG_MARKER_WORD_3: marker_words[3] = value;
                REG_CAPTURE_LIMIT: limit_reg = value[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // Length in use: zero acts as one, anything past the storage is clipped.
        function int active_len();
            int len;
            len = int'(length_reg);
            if (len == 0)
                len = 1;
            if (len > MARKER_BYTES)
                len = MARKER_BYTES;
            return len;
        endfunction

        function logic [7:0] marker_at(int i);
            logic [63:0] word;
            word = marker_words[(i >> 3) & 3];
            return word[(i & 7) * 8 +: 8];
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void push(kind_t k, logic [7:0] b, logic ovf);
            echo_result_t r;
            r.kind = k;
            r.data = b;
            r.ovf  = ovf;
            r.last = 1'b0;
            expected_results.push_back(r);
        endfunction

        // Note one accepted input byte and queue the results it causes.
        function void take_byte(logic [7:0] c);
            int len;
            int first;
            int i;
            len   = active_len();
            first = expected_results.size();

            // Marker scan: hold matching bytes, flush them on a mismatch.
            if (int'(match_pos) < len && c == marker_at(int'(match_pos))) begin
                match_pos = match_pos + 6'd1;
            end
            else begin
                if (int'(match_pos) >= len)
                    capturing = 1'b1;
                else
                    for (i = 0; i < int'(match_pos); i++)
                        push(KIND_ECHO, marker_at(i), 1'b0);
                match_pos = '0;
                push(KIND_ECHO, c, 1'b0);
            end

            // Escape filter and capture counting.
            if (capturing) begin
                if (c == BYTE_ESC) begin
                    in_escape = 1'b1;
                end
                else if (in_escape && c >= BYTE_FINAL_LO && c <= BYTE_FINAL_HI &&
                         c != BYTE_CSI_OPEN) begin
                    in_escape = 1'b0;
                end
                else if (!in_escape && c != BYTE_BACKSPACE) begin
                    if (capture_count < COUNT_W'(limit_reg) && c != BYTE_NUL)
                        push(KIND_CAPT, c, 1'b0);
                    if (capture_count < COUNT_MAX)
                        capture_count = capture_count + COUNT_W'(1);
                end
                if (c == BYTE_NUL) begin
                    push(KIND_END, BYTE_NUL, int'(capture_count) > int'(limit_reg) + 3);
                    capture_count = '0;
                    capturing     = 1'b0;
                end
            end

            if (expected_results.size() > first)
                expected_results[expected_results.size() - 1].last = 1'b1;
        endfunction

        // Compare one delivered result with the oldest one owed.
        function void check_result(kind_t k, logic [7:0] b, logic ovf, logic lst);
            echo_result_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result kind %0d byte %02h", $time, k, b);
                mismatch_count++;
                return;
            end
            want = expected_results.pop_front();
            if (k !== want.kind) begin
                $display("%0t: kind expected %0d actual %0d", $time, want.kind, k);
                mismatch_count++;
            end
            if (b !== want.data) begin
                $display("%0t: out_byte expected %02h actual %02h", $time, want.data, b);
                mismatch_count++;
            end
            if (ovf !== want.ovf) begin
                $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, ovf);
                mismatch_count++;
            end
            if (lst !== want.last) begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, lst);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_MARKER_LENGTH;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [7:0]             in_byte = 8'h00;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    kind_t                  kind;
    logic [7:0]             out_byte;
    logic                   overflow;
    logic                   last;

    echo_capture_tracker tracker;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int bytes_sent = 0;

    marker_detect_escape_strip_capture dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind      (kind),
        .out_byte  (out_byte),
        .overflow  (overflow),
        .last      (last)
    );

    always #5 clk = ~clk;

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Every delivered result goes to the checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(kind, out_byte, overflow, last);
    end

    initial
    begin
        #5000000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Offer one item, with random gaps ahead of it, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_marker();
        int i;
        for (i = 0; i < tracker.active_len(); i++)
            send_byte(tracker.marker_at(i));
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        tracker.write_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic configure(input logic [5:0] len, input logic [3:0][63:0] words,
                             input logic [7:0] lim);
        write_reg(REG_MARKER_LENGTH, 64'(len));
        write_reg(REG_MARKER_WORD_0, words[0]);
        write_reg(REG_MARKER_WORD_1, words[1]);
        write_reg(REG_MARKER_WORD_2, words[2]);
        write_reg(REG_MARKER_WORD_3, words[3]);
        write_reg(REG_CAPTURE_LIMIT, 64'(lim));
        cfg_write <= 1'b0;
    endtask

    function automatic logic [3:0][63:0] rand_words();
        logic [3:0][63:0] w;
        int i;
        for (i = 0; i < 4; i++)
            w[i] = {$urandom, $urandom};
        return w;
    endfunction

    // Drop valid and wait until every owed result is out and the block is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (tracker.pending() != 0);
        repeat (8) @(negedge clk);
    endtask

    // Captured text: plain bytes, backspaces and escape sequences.
    task automatic send_body(input int n);
        int j;
        int r;
        for (j = 0; j < n; j++)
        begin
            r = $urandom_range(99);
            if (r < 12) begin
                send_byte(BYTE_ESC);
                if ($urandom_range(1))
                    send_byte(BYTE_CSI_OPEN);
                repeat ($urandom_range(2))
                    send_byte(8'(8'h30 + $urandom_range(9)));
                send_byte(8'($urandom_range(BYTE_FINAL_LO, BYTE_FINAL_HI)));
            end
            else if (r < 22) begin
                send_byte(BYTE_BACKSPACE);
            end
            else if (r < 30) begin
                send_byte(8'($urandom_range(1, 255)));
            end
            else begin
                send_byte(8'($urandom_range(8'h20, 8'h7E)));
            end
        end
    endtask

    // Mostly marker plus capture plus terminator, the rest broken markers and noise.
    task automatic run_traffic(input int count, input bit pause_mid);
        int start;
        int r;
        int len;
        int k;
        int i;
        bit paused;
        start  = bytes_sent;
        paused = 1'b0;
        len    = tracker.active_len();
        while (bytes_sent - start < count)
        begin
            if (pause_mid && !paused && bytes_sent - start >= count / 2) begin
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (tracker.pending() != 0);
                paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 60) begin
                send_marker();
                send_body($urandom_range(8));
                send_byte(BYTE_NUL);
            end
            else if (r < 75) begin
                k = (len > 1) ? $urandom_range(1, len - 1) : 0;
                for (i = 0; i < k; i++)
                    send_byte(tracker.marker_at(i));
                send_byte(8'($urandom_range(255)));
            end
            else if (r < 85) begin
                send_marker();
                send_byte(8'($urandom_range(255)));
            end
            else begin
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sender idles less than the receiver.
        send_idle_pct = 30;
        recv_idle_pct = 56;

        // Reset marker is all zero bytes: two held zeros flushed by 0xFF.
        send_byte(8'h41);
        send_byte(BYTE_NUL);
        send_byte(BYTE_NUL);
        send_byte(8'hFF);
        settle();

        // Short marker "<#>!" with a small limit.
        configure(6'd4, {64'h0, 64'h0, 64'h0, 64'h0000_0000_213E_233C}, 8'd3);
        // A mismatching byte is echoed and not taken as a new start.
        send_byte(8'h3C);
        send_byte(8'h3C);
        // Zero right after a full match opens and closes a capture at once.
        send_marker();
        send_byte(BYTE_NUL);
        // Capture with an escape sequence, a backspace and text that exactly fills the limit.
        send_marker();
        send_byte("a");
        send_byte(BYTE_ESC);
        send_byte(BYTE_CSI_OPEN);
        send_byte("1");
        send_byte("m");
        send_byte(BYTE_BACKSPACE);
        send_byte("b");
        send_byte("c");
        send_byte(BYTE_NUL);
        settle();

        // Receiver holds off for a long stretch so the block backs up.
        configure(6'($urandom_range(1, 6)), rand_words(), 8'($urandom_range(1, 8)));
        hold_cycles = 300;
        run_traffic(20, 1'b0);
        settle();

        // Receiver idles less than the sender.
        send_idle_pct = 56;
        recv_idle_pct = 30;
        configure(6'd32, rand_words(), 8'd255);
        run_traffic(25, 1'b0);
        settle();

        configure(6'd0, rand_words(), 8'd0);
        run_traffic(15, 1'b0);
        settle();

        // No idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(6'd63, rand_words(), 8'($urandom_range(1, 254)));
        run_traffic(15, 1'b1);
        settle();

        configure(6'($urandom_range(2, 8)), rand_words(), 8'($urandom_range(1, 16)));
        run_traffic(25, 1'b0);
        settle();
        repeat (20) @(negedge clk);

        if (tracker.mismatch_count == 0 && tracker.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
